### rtl/core/rteq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rteq_pkg
// Shared types and constants of the repeating timer event queue.
// ----------------------------------------------------------------------------
package rteq_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

  localparam int ID_W    = 16;
  localparam int DELAY_W = 24;
  localparam int REP_W   = 16;
  localparam int TIME_W  = 32;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_PUSH = 1'b1;

  localparam logic RES_ACK  = 1'b0;
  localparam logic RES_FIRE = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FIRE
  } cmd_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT,
    ST_DECIDE
  } state_e;

  // command broadcast from the controller to all cells
  typedef struct packed {
    cmd_op_e             op;
    logic [SLOT_W-1:0]   idx;
    logic [ID_W-1:0]     id;
    logic [TIME_W-1:0]   deadline;
    logic [DELAY_W-1:0]  period;
    logic [REP_W-1:0]    repeats;
  } cell_cmd_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                due_found;
    logic [TIME_W-1:0]   due_age;
    logic [SLOT_W-1:0]   due_idx;
    logic [ID_W-1:0]     due_id;
    logic [REP_W-1:0]    due_left;
    logic                free_found;
    logic [SLOT_W-1:0]   free_idx;
  } wave_t;

endpackage
`default_nettype wire

### rtl/core/rteq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rteq_cell
// One timer slot. Holds the slot state, merges itself into the search token
// coming from its left neighbor and registers the token toward the right.
// ----------------------------------------------------------------------------
module rteq_cell
  import rteq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SLOT_W-1:0] slot_idx_i,
  input  logic [TIME_W-1:0] time_i,
  input  cell_cmd_t         cmd_i,
  input  wave_t             wave_i,
  output wave_t             wave_o
);

  logic               valid_q, valid_d;
  logic [ID_W-1:0]    id_q, id_d;
  logic [TIME_W-1:0]  deadline_q, deadline_d;
  logic [DELAY_W-1:0] period_q, period_d;
  logic [REP_W-1:0]   repeats_q, repeats_d;
  wave_t              wave_q, wave_d;

  logic [TIME_W-1:0]  age;
  logic [REP_W-1:0]   left;
  logic               due;
  logic               hit;

  always_comb begin
    age  = time_i - deadline_q;
    left = repeats_q - REP_W'(1);
    due  = valid_q && (age != '0) && !age[TIME_W-1];
    hit  = (cmd_i.idx == slot_idx_i);

    wave_d = wave_i;
    if (due && (!wave_i.due_found || (age > wave_i.due_age))) begin
      wave_d.due_found = 1'b1;
      wave_d.due_age   = age;
      wave_d.due_idx   = slot_idx_i;
      wave_d.due_id    = id_q;
      wave_d.due_left  = left;
    end
    if (!valid_q && !wave_i.free_found) begin
      wave_d.free_found = 1'b1;
      wave_d.free_idx   = slot_idx_i;
    end

    valid_d    = valid_q;
    id_d       = id_q;
    deadline_d = deadline_q;
    period_d   = period_q;
    repeats_d  = repeats_q;
    case (cmd_i.op)
      CMD_LOAD: begin
        if (hit) begin
          valid_d    = 1'b1;
          id_d       = cmd_i.id;
          deadline_d = cmd_i.deadline;
          period_d   = cmd_i.period;
          repeats_d  = cmd_i.repeats;
        end
      end
      CMD_FIRE: begin
        if (hit) begin
          if (left != '0) begin
            repeats_d  = left;
            deadline_d = time_i + TIME_W'(period_q);
          end else begin
            valid_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      wave_q  <= '0;
    end else begin
      valid_q <= valid_d;
      wave_q  <= wave_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    deadline_q <= deadline_d;
    period_q   <= period_d;
    repeats_q  <= repeats_d;
  end

  assign wave_o = wave_q;

endmodule
`default_nettype wire

### rtl/core/repeating_timer_event_queue_top.sv
`default_nettype none
// Push: the result is registered after one pass of the search token down the
// SLOTS slot cells and the decide state. A tick that fires k events makes one
// such pass per selection plus a final pass that finds nothing due, each ending
// in the decide state. Output stalls hold the decide state and add their length.
// Next transaction accepted the cycle after the last result is registered.
// Reset clears the time counter and frees all slots.
// ----------------------------------------------------------------------------
// repeating_timer_event_queue_top
// Timer slot table with earliest-deadline-first firing on each tick.
// ----------------------------------------------------------------------------
module repeating_timer_event_queue_top
  import rteq_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [ID_W-1:0]    event_id_i,
  input  logic [DELAY_W-1:0] delay_ticks_i,
  input  logic [REP_W-1:0]   repeat_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               result_kind_o,
  output logic [ID_W-1:0]    fired_id_o,
  output logic               push_accepted_o,
  output logic [REP_W-1:0]   repeats_left_o,
  output logic               last_result_o
);

  state_e              state_q, state_d;
  logic [SLOT_W-1:0]   cnt_q, cnt_d;
  logic [TIME_W-1:0]   time_q, time_d;
  logic                req_q, req_d;
  logic [ID_W-1:0]     pid_q, pid_d;
  logic [DELAY_W-1:0]  pdelay_q, pdelay_d;
  logic [REP_W-1:0]    pcount_q, pcount_d;
  logic [NFIRE_W-1:0]  nfire_q, nfire_d;
  logic                pend_valid_q, pend_valid_d;
  logic [ID_W-1:0]     pend_id_q, pend_id_d;
  logic [REP_W-1:0]    pend_left_q, pend_left_d;

  logic                out_valid_q, out_valid_d;
  logic                out_kind_q, out_kind_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic                out_acc_q, out_acc_d;
  logic [REP_W-1:0]    out_left_q, out_left_d;
  logic                out_last_q, out_last_d;

  logic                out_free;
  logic                in_fire;
  cell_cmd_t           cmd;
  wave_t               waves [SLOTS+1];
  wave_t               tail;

  assign waves[0] = '0;
  assign tail     = waves[SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    rteq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .slot_idx_i (SLOT_W'(g)),
      .time_i     (time_q),
      .cmd_i      (cmd),
      .wave_i     (waves[g]),
      .wave_o     (waves[g+1])
    );
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    time_d       = time_q;
    req_d        = req_q;
    pid_d        = pid_q;
    pdelay_d     = pdelay_q;
    pcount_d     = pcount_q;
    nfire_d      = nfire_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    pend_left_d  = pend_left_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_kind_d   = out_kind_q;
    out_id_d     = out_id_q;
    out_acc_d    = out_acc_q;
    out_left_d   = out_left_q;
    out_last_d   = out_last_q;

    cmd          = '0;
    cmd.op       = CMD_NONE;
    cmd.deadline = time_q + TIME_W'(pdelay_q);
    cmd.id       = pid_q;
    cmd.period   = pdelay_q;
    cmd.repeats  = (pcount_q == '0) ? REP_W'(1) : pcount_q;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          req_d        = req_type_i;
          pid_d        = event_id_i;
          pdelay_d     = delay_ticks_i;
          pcount_d     = repeat_count_i;
          nfire_d      = '0;
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          if (req_type_i == REQ_TICK) begin
            time_d = time_q + TIME_W'(1);
          end
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        cnt_d = cnt_q + SLOT_W'(1);
        if (cnt_q == SLOT_W'(SLOTS - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (req_q == REQ_PUSH) begin
            out_valid_d = 1'b1;
            out_kind_d  = RES_ACK;
            out_id_d    = pid_q;
            out_acc_d   = tail.free_found;
            out_left_d  = '0;
            out_last_d  = 1'b1;
            if (tail.free_found) begin
              cmd.op  = CMD_LOAD;
              cmd.idx = tail.free_idx;
            end
            state_d = ST_IDLE;
          end else if (tail.due_found && (nfire_q < NFIRE_W'(MAX_RESULTS))) begin
            cmd.op  = CMD_FIRE;
            cmd.idx = tail.due_idx;
            nfire_d = nfire_q + NFIRE_W'(1);
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = RES_FIRE;
              out_id_d    = pend_id_q;
              out_acc_d   = 1'b0;
              out_left_d  = pend_left_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_id_d    = tail.due_id;
            pend_left_d  = tail.due_left;
            cnt_d        = '0;
            state_d      = ST_WAIT;
          end else begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = RES_FIRE;
              out_id_d    = pend_id_q;
              out_acc_d   = 1'b0;
              out_left_d  = pend_left_q;
              out_last_d  = 1'b1;
            end
            pend_valid_d = 1'b0;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      time_q       <= '0;
      nfire_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      time_q       <= time_d;
      nfire_q      <= nfire_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    pid_q       <= pid_d;
    pdelay_q    <= pdelay_d;
    pcount_q    <= pcount_d;
    pend_id_q   <= pend_id_d;
    pend_left_q <= pend_left_d;
    out_kind_q  <= out_kind_d;
    out_id_q    <= out_id_d;
    out_acc_q   <= out_acc_d;
    out_left_q  <= out_left_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_kind_o   = out_kind_q;
  assign fired_id_o      = out_id_q;
  assign push_accepted_o = out_acc_q;
  assign repeats_left_o  = out_left_q;
  assign last_result_o   = out_last_q;

endmodule
`default_nettype wire
